FILE: hdl/eave_pkg.sv
// Shared types, constants and configuration codes of the encoder angle and velocity estimator.
`default_nettype none

package eave_pkg;

    localparam int DEFAULT_ANGLE_BITS = 21;
    localparam int DEFAULT_ACC_BITS   = 32;

    localparam int BYTE_BITS   = 8;
    localparam int WORD_BITS   = 3 * BYTE_BITS;
    localparam int POLE_BITS   = 7;
    localparam int OFFSET_BITS = 21;
    localparam int EVEL_BITS   = 38;
    localparam int CFG_DATA_BITS  = OFFSET_BITS;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [POLE_BITS-1:0] POLE_PAIRS_RESET = 7'd7;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_DIRECTION  = 2'd0,
        REG_POLE_PAIRS = 2'd1,
        REG_OFFSET     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic                   direction_negative;
        logic [POLE_BITS-1:0]   pole_pairs;
        logic [OFFSET_BITS-1:0] electrical_offset;
    } cfg_t;

endpackage

`default_nettype wire

FILE: hdl/eave_angle_unit.sv
// Sample path: electrical angle and saturating accumulation of the wrapped angle delta.
`default_nettype none

module eave_angle_unit
    import eave_pkg::*;
#(
    parameter int ANGLE_BITS = DEFAULT_ANGLE_BITS,
    parameter int ACC_BITS   = DEFAULT_ACC_BITS
)
(
    input  wire logic        [ANGLE_BITS-1:0] raw_angle,
    input  wire logic        [ANGLE_BITS-1:0] prev_raw,
    input  wire logic signed [ACC_BITS-1:0]   acc,
    input  wire cfg_t                         cfg,
    output logic             [ANGLE_BITS-1:0] elec_angle,
    output logic signed      [ACC_BITS-1:0]   acc_next
);

    localparam int DW = ANGLE_BITS + 2;
    localparam int PW = ANGLE_BITS + POLE_BITS;
    localparam logic signed [DW-1:0] HALF = DW'(1) << (ANGLE_BITS - 1);
    localparam logic signed [DW-1:0] TURN = DW'(1) << ANGLE_BITS;
    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    logic        [PW-1:0]                    elec_prod;
    logic        [ANGLE_BITS-1:0]            elec_dir;
    logic        [ANGLE_BITS+OFFSET_BITS-1:0] offset_ext;
    logic signed [DW-1:0]                    angle_diff;
    logic signed [DW-1:0]                    delta;
    logic signed [ACC_BITS:0]                delta_ext;
    logic signed [ACC_BITS:0]                acc_sum;

    // The product is only needed modulo one turn.
    assign elec_prod  = PW'(raw_angle) * PW'(cfg.pole_pairs);
    assign elec_dir   = cfg.direction_negative ? ANGLE_BITS'(-elec_prod[ANGLE_BITS-1:0])
                                               : elec_prod[ANGLE_BITS-1:0];
    assign offset_ext = {{ANGLE_BITS{1'b0}}, cfg.electrical_offset};
    assign elec_angle = elec_dir - offset_ext[ANGLE_BITS-1:0];

    // Shortest path delta; a delta of exactly half a turn keeps its sign.
    assign angle_diff = $signed(DW'(raw_angle)) - $signed(DW'(prev_raw));

    always_comb
    begin
        if (angle_diff > HALF)
        begin
            delta = angle_diff - TURN;
        end
        else if (angle_diff < -HALF)
        begin
            delta = angle_diff + TURN;
        end
        else
        begin
            delta = angle_diff;
        end
    end

    assign delta_ext = (ACC_BITS+1)'(delta);
    assign acc_sum   = (ACC_BITS+1)'(acc) + delta_ext;

    always_comb
    begin
        if (acc_sum[ACC_BITS] != acc_sum[ACC_BITS-1])
        begin
            acc_next = acc_sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_next = acc_sum[ACC_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/eave_velocity_unit.sv
// Tick path: velocity averaging filter and electrical velocity with saturation.
`default_nettype none

module eave_velocity_unit
    import eave_pkg::*;
#(
    parameter int ACC_BITS = DEFAULT_ACC_BITS
)
(
    input  wire logic                       is_tick,
    input  wire logic signed [ACC_BITS-1:0] acc,
    input  wire logic signed [ACC_BITS-1:0] filt,
    input  wire cfg_t                       cfg,
    output logic signed      [ACC_BITS-1:0] filt_next,
    output logic signed      [EVEL_BITS-1:0] elec_vel
);

    localparam int PW = ACC_BITS + POLE_BITS + 1;
    localparam int SW = (PW > EVEL_BITS) ? PW : EVEL_BITS;
    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
    localparam logic signed [SW-1:0] EV_MAX = SW'({1'b0, {(EVEL_BITS-1){1'b1}}});
    localparam logic signed [SW-1:0] EV_MIN = -EV_MAX - SW'(1);

    logic signed [ACC_BITS-1:0] raw_vel;
    logic signed [ACC_BITS:0]   vel_sum;
    logic signed [ACC_BITS-1:0] vel_src;
    logic signed [PW-1:0]       vel_prod;
    logic signed [SW-1:0]       prod_ext;

    // Negating the most negative count saturates to the most positive one.
    always_comb
    begin
        if (!cfg.direction_negative)
        begin
            raw_vel = acc;
        end
        else if (acc == ACC_MIN)
        begin
            raw_vel = ACC_MAX;
        end
        else
        begin
            raw_vel = -acc;
        end
    end

    // The halved sum of two in-range values always stays in range.
    assign vel_sum   = (ACC_BITS+1)'(raw_vel) + (ACC_BITS+1)'(filt);
    assign filt_next = vel_sum[ACC_BITS:1];

    assign vel_src  = is_tick ? filt_next : filt;
    assign vel_prod = PW'(vel_src) * $signed(PW'(cfg.pole_pairs));
    assign prod_ext = SW'(vel_prod);

    always_comb
    begin
        if (prod_ext > EV_MAX)
        begin
            elec_vel = EV_MAX[EVEL_BITS-1:0];
        end
        else if (prod_ext < EV_MIN)
        begin
            elec_vel = EV_MIN[EVEL_BITS-1:0];
        end
        else
        begin
            elec_vel = prod_ext[EVEL_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/encoder_angle_velocity_estimator.sv
// Top level of the encoder angle and velocity estimator.
// An item is taken into the input register, and its result is moved into the result register
// and offered once that register is empty or its result is being taken. The state update of an
// item completes in the cycle it is computed. Throughput: one item per cycle while not stalled.
// The input stage keeps accepting while a result waits, until both stages are full.
// Reset (rst_n low, asynchronous) clears the pipeline, the angle and velocity state,
// and sets direction +1, seven pole pairs and a zero offset.
`default_nettype none

module encoder_angle_velocity_estimator
    import eave_pkg::*;
#(
    parameter int ANGLE_BITS = DEFAULT_ANGLE_BITS,
    parameter int ACC_BITS   = DEFAULT_ACC_BITS
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // byte_high [7:0], byte_mid [15:8], byte_low [23:16]
    input  wire logic [WORD_BITS-1:0]          s_tdata,
    // command [0]
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // mech_angle, elec_angle, mech_velocity, electrical_velocity,
    // from the lowest bit up, then zero fill to whole bytes
    output logic [((2*ANGLE_BITS+ACC_BITS+EVEL_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int RES_BITS   = 2 * ANGLE_BITS + ACC_BITS + EVEL_BITS;
    localparam int TDATA_BITS = ((RES_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic signed [EVEL_BITS-1:0]  electrical_velocity;
        logic signed [ACC_BITS-1:0]   mech_velocity;
        logic        [ANGLE_BITS-1:0] elec_angle;
        logic        [ANGLE_BITS-1:0] mech_angle;
    } result_t;

    cfg_t                         cfg_reg;
    logic                         in_valid_reg;
    logic                         in_cmd_reg;
    logic [WORD_BITS-1:0]         in_word_reg;
    logic                         out_valid_reg;
    result_t                      out_reg;
    result_t                      out_next;

    logic        [ANGLE_BITS-1:0] prev_raw_reg;
    logic        [ANGLE_BITS-1:0] prev_raw_next;
    logic signed [ACC_BITS-1:0]   acc_reg;
    logic signed [ACC_BITS-1:0]   acc_next;
    logic signed [ACC_BITS-1:0]   filt_reg;
    logic signed [ACC_BITS-1:0]   filt_next;
    logic        [ANGLE_BITS-1:0] mech_reg;
    logic        [ANGLE_BITS-1:0] mech_next;
    logic        [ANGLE_BITS-1:0] elec_reg;
    logic        [ANGLE_BITS-1:0] elec_next;

    logic                         advance;
    logic                         is_tick;
    logic        [ANGLE_BITS-1:0] raw_angle;
    logic        [ANGLE_BITS-1:0] sample_elec;
    logic signed [ACC_BITS-1:0]   sample_acc;
    logic signed [ACC_BITS-1:0]   tick_filt;
    logic signed [EVEL_BITS-1:0]  elec_vel;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_BITS'(out_reg);

    assign is_tick   = (in_cmd_reg == CMD_TICK);
    assign raw_angle = in_word_reg[WORD_BITS-1 -: ANGLE_BITS];

    eave_angle_unit #(
        .ANGLE_BITS (ANGLE_BITS),
        .ACC_BITS   (ACC_BITS)
    ) u_angle (
        .raw_angle  (raw_angle),
        .prev_raw   (prev_raw_reg),
        .acc        (acc_reg),
        .cfg        (cfg_reg),
        .elec_angle (sample_elec),
        .acc_next   (sample_acc)
    );

    eave_velocity_unit #(
        .ACC_BITS (ACC_BITS)
    ) u_velocity (
        .is_tick   (is_tick),
        .acc       (acc_reg),
        .filt      (filt_reg),
        .cfg       (cfg_reg),
        .filt_next (tick_filt),
        .elec_vel  (elec_vel)
    );

    always_comb
    begin
        prev_raw_next = prev_raw_reg;
        acc_next      = acc_reg;
        filt_next     = filt_reg;
        mech_next     = mech_reg;
        elec_next     = elec_reg;
        if (is_tick)
        begin
            filt_next = tick_filt;
            acc_next  = '0;
        end
        else
        begin
            prev_raw_next = raw_angle;
            acc_next      = sample_acc;
            mech_next     = raw_angle;
            elec_next     = sample_elec;
        end
        out_next.mech_angle          = mech_next;
        out_next.elec_angle          = elec_next;
        out_next.mech_velocity       = filt_next;
        out_next.electrical_velocity = elec_vel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direction_negative <= 1'b0;
            cfg_reg.pole_pairs         <= POLE_PAIRS_RESET;
            cfg_reg.electrical_offset  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DIRECTION:  cfg_reg.direction_negative <= cfg_data[0];
                REG_POLE_PAIRS: cfg_reg.pole_pairs         <= cfg_data[POLE_BITS-1:0];
                REG_OFFSET:     cfg_reg.electrical_offset  <= cfg_data;
                default:        cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_raw_reg  <= '0;
            acc_reg       <= '0;
            filt_reg      <= '0;
            mech_reg      <= '0;
            elec_reg      <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                prev_raw_reg  <= prev_raw_next;
                acc_reg       <= acc_next;
                filt_reg      <= filt_next;
                mech_reg      <= mech_next;
                elec_reg      <= elec_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg  <= s_tuser;
            in_word_reg <= {s_tdata[BYTE_BITS-1:0], s_tdata[2*BYTE_BITS-1:BYTE_BITS],
                            s_tdata[3*BYTE_BITS-1:2*BYTE_BITS]};
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/eave_checker.sv
// Port-level checks of the estimator's flow control, bound to the top level.
`default_nettype none

module eave_port_checks
    import eave_pkg::*;
#(
    parameter int ANGLE_BITS = DEFAULT_ANGLE_BITS,
    parameter int ACC_BITS   = DEFAULT_ACC_BITS
)
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [((2*ANGLE_BITS+ACC_BITS+EVEL_BITS+7)/8)*8-1:0] m_tdata
);

    // A result that is not taken stays offered with the same payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // After an item is accepted, the output must offer a result.
    a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("accepted item did not reach the result register");

    // The input side only stalls when the output side holds a waiting result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

endmodule

bind encoder_angle_velocity_estimator eave_port_checks #(
    .ANGLE_BITS (ANGLE_BITS),
    .ACC_BITS   (ACC_BITS)
) u_eave_port_checks (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
